// ----- rtl/bhsl_pkg.sv -----
package bhsl_pkg;

    localparam int CNT_W     = 16;
    localparam int SLOT_W    = 3;
    localparam int LED_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DFU_HOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd3;

    localparam logic [CNT_W-1:0] HOLD_MIN_RST   = 16'd30;
    localparam logic [CNT_W-1:0] LAUNCH_MAX_RST = 16'd150;
    localparam logic [CNT_W-1:0] DFU_HOLD_RST   = 16'd300;
    localparam logic [CNT_W-1:0] IDLE_LIMIT_RST = 16'd1500;

    // LED patterns
    localparam logic [LED_W-1:0] LED_OFF   = 4'h0;
    localparam logic [LED_W-1:0] LED_ARMED = 4'h7;
    localparam logic [LED_W-1:0] LED_LONG  = 4'h8;

    typedef struct packed {
        logic button_level;
        logic host_activity;
    } in_word_t;

    typedef struct packed {
        logic [LED_W-1:0]  led_pattern;
        logic              launch_pulse;
        logic [SLOT_W-1:0] launch_slot;
        logic              dfu_request;
        logic              fade_start;
        logic              restore_start;
    } out_word_t;

    typedef struct packed {
        logic [CNT_W-1:0] hold_min_samples;
        logic [CNT_W-1:0] launch_max_samples;
        logic [CNT_W-1:0] dfu_hold_samples;
        logic [CNT_W-1:0] idle_limit_samples;
    } cfg_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_sel;
        logic              prev_pressed;
        logic [CNT_W-1:0]  press_count;
        logic [CNT_W-1:0]  idle_count;
        logic              faded_flag;
        logic              swallow_flag;
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ----- rtl/bhsl_cfg.sv -----
module bhsl_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               we,
    input  logic [bhsl_pkg::CFG_IDX_W-1:0]     index,
    input  logic [bhsl_pkg::CFG_DAT_W-1:0]     data,
    output bhsl_pkg::cfg_t                     cfg
);

    bhsl_pkg::cfg_t cfg_reg;
    bhsl_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            case (index)
                bhsl_pkg::REG_HOLD_MIN:   cfg_next.hold_min_samples   = data;
                bhsl_pkg::REG_LAUNCH_MAX: cfg_next.launch_max_samples = data;
                bhsl_pkg::REG_DFU_HOLD:   cfg_next.dfu_hold_samples   = data;
                bhsl_pkg::REG_IDLE_LIMIT: cfg_next.idle_limit_samples = data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_min_samples   <= bhsl_pkg::HOLD_MIN_RST;
            cfg_reg.launch_max_samples <= bhsl_pkg::LAUNCH_MAX_RST;
            cfg_reg.dfu_hold_samples   <= bhsl_pkg::DFU_HOLD_RST;
            cfg_reg.idle_limit_samples <= bhsl_pkg::IDLE_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/bhsl_step.sv -----
module bhsl_step (
    input  bhsl_pkg::cfg_t     cfg,
    input  bhsl_pkg::state_t   state,
    input  bhsl_pkg::in_word_t word,
    output bhsl_pkg::state_t   state_next,
    output bhsl_pkg::out_word_t result
);

    logic                          now;
    logic                          idle;
    logic [bhsl_pkg::CNT_W-1:0]    idle_cnt;
    logic [bhsl_pkg::CNT_W-1:0]    press_inc;
    logic [bhsl_pkg::CNT_W-1:0]    press_held;
    logic [bhsl_pkg::LED_W-1:0]    slot_led;

    assign now       = word.button_level;
    assign idle_cnt  = (word.button_level || word.host_activity) ? '0
                                                                  : bhsl_pkg::sat_inc(state.idle_count);
    assign idle      = (idle_cnt >= cfg.idle_limit_samples);
    assign press_inc = bhsl_pkg::sat_inc(state.press_count);
    assign press_held = state.prev_pressed ? press_inc : '0;

    always_comb
    begin
        state_next            = state;
        state_next.idle_count = idle_cnt;
        result                = '0;
        slot_led              = {1'b0, state.slot_sel};

        if (idle && !state.faded_flag)
        begin
            state_next.faded_flag = 1'b1;
            result.fade_start     = 1'b1;
            result.led_pattern    = bhsl_pkg::LED_OFF;
        end
        else if (!idle && state.faded_flag)
        begin
            // wake up; a press held now is swallowed until release
            state_next.faded_flag   = 1'b0;
            state_next.prev_pressed = 1'b0;
            state_next.swallow_flag = now;
            result.restore_start    = 1'b1;
            result.led_pattern      = slot_led;
        end
        else if (state.faded_flag)
        begin
            result.led_pattern = bhsl_pkg::LED_OFF;
        end
        else if (state.swallow_flag)
        begin
            if (!now)
            begin
                state_next.swallow_flag = 1'b0;
                state_next.prev_pressed = 1'b0;
            end
            result.led_pattern = slot_led;
        end
        else
        begin
            state_next.prev_pressed = now;
            if (now)
            begin
                state_next.press_count = press_held;
                if (press_held >= cfg.dfu_hold_samples)
                begin
                    result.dfu_request = 1'b1;
                    result.led_pattern = bhsl_pkg::LED_OFF;
                end
                else if (press_held >= cfg.launch_max_samples)
                    result.led_pattern = bhsl_pkg::LED_LONG;
                else if (press_held >= cfg.hold_min_samples)
                    result.led_pattern = bhsl_pkg::LED_ARMED;
                else
                    result.led_pattern = slot_led;
            end
            else
            begin
                result.led_pattern = slot_led;
                if (state.prev_pressed)
                begin
                    state_next.press_count = press_inc;
                    if (press_inc >= cfg.hold_min_samples &&
                        press_inc < cfg.launch_max_samples)
                        result.launch_pulse = 1'b1;
                    else if (press_inc < cfg.hold_min_samples)
                    begin
                        state_next.slot_sel = state.slot_sel + 1'b1;
                        result.led_pattern  = {1'b0, state.slot_sel + 1'b1};
                    end
                end
            end
        end

        result.launch_slot = state_next.slot_sel;
    end

endmodule

// ----- rtl/button_hold_slot_launcher.sv -----
// Button hold slot launcher: long-press detector, one sample word per handshake.
// The accepted word waits in the input register; its result is then registered into
// the result stage. Throughput: one word per cycle while out_ready stays high.
// While a finished word waits downstream the input register takes one more word,
// then in_ready drops until out_ready returns.
// Reset (rst_n, async, active low): slot 0, counters and flags cleared,
// thresholds back to 30 / 150 / 300 / 1500 samples, both stages empty.
module button_hold_slot_launcher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bhsl_pkg::in_word_t              in_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bhsl_pkg::out_word_t             out_word,
    input  logic                            cfg_we,
    input  logic [bhsl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bhsl_pkg::CFG_DAT_W-1:0]  cfg_data
);

    // input stage
    logic                 s1_valid_reg;
    bhsl_pkg::in_word_t   s1_word_reg;

    // result stage
    logic                 out_valid_reg;
    bhsl_pkg::out_word_t  out_word_reg;

    // detector state, updated once per word as it moves into the result stage
    bhsl_pkg::state_t     state_reg;
    bhsl_pkg::state_t     state_next;
    bhsl_pkg::out_word_t  result;
    bhsl_pkg::cfg_t       cfg;

    logic                 advance;

    bhsl_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    bhsl_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .word       (s1_word_reg),
        .state_next (state_next),
        .result     (result)
    );

    // word moves forward when the result slot is empty or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_word_reg <= in_word;
        if (advance)
            out_word_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- rtl/button_hold_slot_launcher_chk.sv -----
module button_hold_slot_launcher_chk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  bhsl_pkg::out_word_t             out_word
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // fade and restore are exclusive
    a_fade_restore: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_word.fade_start && out_word.restore_start))
        else $error("fade and restore in one word");

    // firmware request shows dark LEDs and no launch
    a_dfu_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.dfu_request |->
            out_word.led_pattern == bhsl_pkg::LED_OFF && !out_word.launch_pulse)
        else $error("dfu request with LEDs lit or launch");

    // fade start darkens LEDs
    a_fade_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.fade_start |-> out_word.led_pattern == bhsl_pkg::LED_OFF)
        else $error("fade start with LEDs lit");

    // a launch displays the launched slot
    a_launch_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.launch_pulse |->
            out_word.led_pattern == {1'b0, out_word.launch_slot})
        else $error("launch without slot display");

endmodule

bind button_hold_slot_launcher button_hold_slot_launcher_chk u_chk (.*);

// ----- test/bhsl_checker.sv -----
module bhsl_checker
    import bhsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_word_t              in_word,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_word_t             out_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,
    output int                    pending_words,
    output int                    mismatch_count
);

    cfg_t              limits;
    logic [SLOT_W-1:0] slot_now;
    logic              held_last;
    logic [CNT_W-1:0]  hold_len;
    logic [CNT_W-1:0]  quiet_len;
    logic              dark;
    logic              ignore_press;

    out_word_t expected_words [$];
    int        errs;
    int        seen;

    // one sample in, one result word out; updates the tracked state
    function automatic out_word_t next_led_word(input in_word_t w);
        out_word_t r;
        logic      idle_now;
        r = '0;
        if (w.button_level || w.host_activity)
            quiet_len = '0;
        else if (quiet_len != CNT_MAX)
            quiet_len = quiet_len + 1'b1;
        idle_now = (quiet_len >= limits.idle_limit_samples);

        if (idle_now && !dark)
        begin
            dark = 1'b1;
            r.fade_start = 1'b1;
            r.led_pattern = LED_OFF;
        end
        else if (!idle_now && dark)
        begin
            dark = 1'b0;
            r.restore_start = 1'b1;
            held_last = 1'b0;
            ignore_press = w.button_level;
            r.led_pattern = {1'b0, slot_now};
        end
        else if (dark)
        begin
            r.led_pattern = LED_OFF;
        end
        else if (ignore_press)
        begin
            if (!w.button_level)
            begin
                ignore_press = 1'b0;
                held_last = 1'b0;
            end
            r.led_pattern = {1'b0, slot_now};
        end
        else
        begin
            if (w.button_level)
            begin
                if (!held_last)
                    hold_len = '0;
                else if (hold_len != CNT_MAX)
                    hold_len = hold_len + 1'b1;
                if (hold_len >= limits.dfu_hold_samples)
                begin
                    r.dfu_request = 1'b1;
                    r.led_pattern = LED_OFF;
                end
                else if (hold_len >= limits.launch_max_samples)
                    r.led_pattern = LED_LONG;
                else if (hold_len >= limits.hold_min_samples)
                    r.led_pattern = LED_ARMED;
                else
                    r.led_pattern = {1'b0, slot_now};
            end
            else
            begin
                if (held_last)
                begin
                    if (hold_len != CNT_MAX)
                        hold_len = hold_len + 1'b1;
                    if (hold_len >= limits.hold_min_samples &&
                        hold_len < limits.launch_max_samples)
                        r.launch_pulse = 1'b1;
                    else if (hold_len < limits.hold_min_samples)
                        slot_now = slot_now + 1'b1;
                end
                r.led_pattern = {1'b0, slot_now};
            end
            held_last = w.button_level;
        end
        r.launch_slot = slot_now;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits.hold_min_samples   = HOLD_MIN_RST;
            limits.launch_max_samples = LAUNCH_MAX_RST;
            limits.dfu_hold_samples   = DFU_HOLD_RST;
            limits.idle_limit_samples = IDLE_LIMIT_RST;
            slot_now     = '0;
            held_last    = 1'b0;
            hold_len     = '0;
            quiet_len    = '0;
            dark         = 1'b0;
            ignore_press = 1'b0;
            expected_words.delete();
            errs = 0;
            seen = 0;
            pending_words  <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HOLD_MIN:   limits.hold_min_samples   = cfg_data;
                    REG_LAUNCH_MAX: limits.launch_max_samples = cfg_data;
                    REG_DFU_HOLD:   limits.dfu_hold_samples   = cfg_data;
                    REG_IDLE_LIMIT: limits.idle_limit_samples = cfg_data;
                    default:        ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                out_word_t exp_w;
                exp_w = '0;
                seen++;
                if (expected_words.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("result word %0d arrived with nothing pending", seen);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_word.led_pattern   !== exp_w.led_pattern   ||
                        out_word.launch_pulse  !== exp_w.launch_pulse  ||
                        out_word.launch_slot   !== exp_w.launch_slot   ||
                        out_word.dfu_request   !== exp_w.dfu_request   ||
                        out_word.fade_start    !== exp_w.fade_start    ||
                        out_word.restore_start !== exp_w.restore_start)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display("word %0d: exp led=%h launch=%b slot=%0d dfu=%b fade=%b restore=%b",
                                     seen, exp_w.led_pattern, exp_w.launch_pulse,
                                     exp_w.launch_slot, exp_w.dfu_request,
                                     exp_w.fade_start, exp_w.restore_start);
                            $display("word %0d: got led=%h launch=%b slot=%0d dfu=%b fade=%b restore=%b",
                                     seen, out_word.led_pattern, out_word.launch_pulse,
                                     out_word.launch_slot, out_word.dfu_request,
                                     out_word.fade_start, out_word.restore_start);
                        end
                    end
                end
            end

            if (in_valid && in_ready)
                expected_words.push_back(next_led_word(in_word));

            pending_words  <= expected_words.size();
            mismatch_count <= errs;
        end
    end

endmodule

// ----- test/button_hold_slot_launcher_tb.sv -----
module button_hold_slot_launcher_tb;

    import bhsl_pkg::*;

    // cap on the whole run; the slowest legal run is far below this
    localparam int LIMIT_CYCLES    = 1_000_000;
    // receiver hold-off long enough to back the block up to its input
    localparam int HOLD_OFF_CYCLES = 200;
    // settle time after the last word drains (block holds at most two words)
    localparam int SETTLE_CYCLES   = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    in_word_t              in_word   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    logic      in_ready;
    logic      out_valid;
    out_word_t out_word;

    int pending_words;
    int mismatch_count;

    // sender idle chance lives in the stimulus process; the receiver one is
    // read by another process, so it only changes by nonblocking assignment
    int   sender_idle_pct = 0;
    int   recv_idle_pct   = 0;
    logic hold_off_arm    = 1'b0;
    logic hold_off_done   = 1'b0;
    int   cycle_count     = 0;
    int   sent            = 0;

    // thresholds last written; only used to shape the stimulus
    cfg_t cur_cfg;

    button_hold_slot_launcher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bhsl_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_word       (out_word),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pending_words  (pending_words),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off when armed so the
    // block fills up and has to drop in_ready
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_arm && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic coin();
        return $urandom_range(1) == 1;
    endfunction

    // offer one sample word; random idle cycles go in front of it, and
    // valid stays up with a steady payload until the handshake
    task automatic send_sample(input logic btn, input logic act);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= {btn, act};
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    // held samples followed by one released sample; host activity random
    task automatic press_button(input int held);
        repeat (held) send_sample(1'b1, coin());
        send_sample(1'b0, coin());
    endtask

    task automatic quiet(input int n);
        repeat (n) send_sample(1'b0, 1'b0);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // write all four thresholds back to back; only called with the block idle
    task automatic load_limits(input logic [CFG_DAT_W-1:0] hold_min,
                               input logic [CFG_DAT_W-1:0] abandon_at,
                               input logic [CFG_DAT_W-1:0] dfu_hold,
                               input logic [CFG_DAT_W-1:0] idle_limit);
        put_reg(REG_HOLD_MIN, hold_min);
        put_reg(REG_LAUNCH_MAX, abandon_at);
        put_reg(REG_DFU_HOLD, dfu_hold);
        put_reg(REG_IDLE_LIMIT, idle_limit);
        cfg_we <= 1'b0;
        cur_cfg.hold_min_samples   = hold_min;
        cur_cfg.launch_max_samples = abandon_at;
        cur_cfg.dfu_hold_samples   = dfu_hold;
        cur_cfg.idle_limit_samples = idle_limit;
    endtask

    // drop valid, wait for every predicted word to come back, then let the
    // pipe settle; the checker's count is registered, hence the first edge
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one gesture: mostly clean presses up to just past the firmware threshold (at most 40
    // held samples), some idle-out-and-wake sequences, the rest raw noise
    task automatic random_gesture();
        int pick;
        int reach;
        int lim;
        pick  = $urandom_range(99);
        reach = int'(cur_cfg.dfu_hold_samples);
        reach = (reach > 37) ? 40 : reach + 3;
        lim   = int'(cur_cfg.idle_limit_samples);
        if (pick < 60)
        begin
            press_button($urandom_range(reach, 1));
            quiet($urandom_range(3, 0));
        end
        else if (pick < 75)
        begin
            // go dark (when the limit is reachable), then wake by press or host
            quiet((lim > 37) ? $urandom_range(40, 1) : lim + $urandom_range(3, 0));
            if (coin())
                press_button($urandom_range(3, 1));
            else
                send_sample(1'b0, 1'b1);
        end
        else
        begin
            repeat ($urandom_range(6, 1)) send_sample(coin(), coin());
        end
    endtask

    task automatic run_random(input int samples);
        int target;
        target = sent + samples;
        while (sent < target) random_gesture();
    endtask

    initial
    begin
        cur_cfg.hold_min_samples   = HOLD_MIN_RST;
        cur_cfg.launch_max_samples = LAUNCH_MAX_RST;
        cur_cfg.dfu_hold_samples   = DFU_HOLD_RST;
        cur_cfg.idle_limit_samples = IDLE_LIMIT_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: a press near the 30-sample launch edge
        press_button($urandom_range(40, 25));
        drain();

        // directed part on tight thresholds: advance, launch, long hold,
        // firmware request, fade, waking press swallowed, host-only wake
        load_limits(16'd2, 16'd3, 16'd4, 16'd4);
        press_button(1);
        press_button(2);
        press_button(4);
        press_button(5);
        quiet(4);
        press_button(2);
        quiet(4);
        send_sample(1'b0, 1'b1);
        drain();

        // sender idles lightly, receiver heavily
        sender_idle_pct = 36;
        recv_idle_pct <= 70;
        load_limits(16'd3, 16'd7, 16'd10, 16'd15);
        run_random(120);
        drain();
        // thresholds out of order
        load_limits(16'd9, 16'd4, 16'd6, 16'd12);
        run_random(60);
        drain();

        // the other way round; extremes of the register range
        sender_idle_pct = 70;
        recv_idle_pct <= 36;
        load_limits(16'd1, CNT_MAX, CNT_MAX, 16'd1);
        run_random(40);
        drain();
        // zero idle limit: dark from the first sample
        load_limits(16'd2, 16'd5, 16'd8, 16'd0);
        run_random(30);
        drain();
        load_limits(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);
        run_random(60);
        drain();

        // no idling; the receiver hold-off lands at the start of this phase
        sender_idle_pct = 0;
        recv_idle_pct <= 0;
        load_limits(16'd3, 16'd7, 16'd10, 16'd15);
        hold_off_arm <= 1'b1;
        run_random(120);
        drain();

        if (mismatch_count == 0 && pending_words == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
